@@ sv/sss_pkg.sv @@
// ----------------------------------------------------------------------------
// sss_pkg
// Shared widths, controller states and the command and status bundles that
// connect the sample set statistics controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sss_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int COUNT_W    = 17;
    localparam int SUM_W      = 40;
    localparam int SQSUM_W    = 64;
    localparam int SQUARE_W   = 2 * SAMPLE_W;
    localparam int VAR_W      = 48;
    localparam int ROOT_W     = VAR_W / 2;
    localparam int IN_DATA_W  = 24;
    // mean, variance, deviation, min, max, count packed, padded to bytes
    localparam int OUT_FIELDS_W = SAMPLE_W + VAR_W + ROOT_W + SAMPLE_W + SAMPLE_W + COUNT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int DEFAULT_MAX_SAMPLES = 65536;
    localparam int DEFAULT_SAMPLE_BITS = 24;

    typedef enum logic [3:0] {
        ST_ACCUM,
        ST_MEAN_START,
        ST_MEAN_WAIT,
        ST_MSQ_START,
        ST_MSQ_WAIT,
        ST_VAR,
        ST_ROOT_START,
        ST_ROOT_WAIT,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic acc_en;
        logic div_start;
        logic div_msq;
        logic take_mean;
        logic take_msq;
        logic var_load;
        logic root_start;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic root_done;
    } status_t;

endpackage

`default_nettype wire

@@ sv/sss_divider.sv @@
// ----------------------------------------------------------------------------
// sss_divider
// Restoring divider, one quotient bit per cycle, shared by the mean and the
// mean-square divisions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sss_divider #(
    parameter int DIVIDEND_W = sss_pkg::SQSUM_W,
    parameter int DIVISOR_W  = sss_pkg::COUNT_W
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       done,
    output logic [DIVIDEND_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  div_reg;
    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    rem_diff;
    logic                  fits;

    // bring the next dividend bit down into the partial remainder
    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits      = rem_shift >= {1'b0, div_reg};
    assign rem_diff  = rem_shift - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

@@ sv/sss_isqrt.sv @@
// ----------------------------------------------------------------------------
// sss_isqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sss_isqrt #(
    parameter int VALUE_W = sss_pkg::VAR_W
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [VALUE_W-1:0]     value,
    output logic                        done,
    output logic [VALUE_W/2-1:0]        root
);

    localparam int RT_W  = VALUE_W / 2;
    localparam int REM_W = RT_W + 3;
    localparam int CNT_W = $clog2(RT_W);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [RT_W-1:0]    root_reg;
    logic [REM_W-1:0]   rem_shift;
    logic [REM_W-1:0]   trial;
    logic               fits;

    // two value bits join the remainder each step, trial is 4*root + 1
    assign rem_shift = {rem_reg[REM_W-3:0], val_reg[VALUE_W-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign fits      = rem_shift >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(RT_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= value;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg  <= {val_reg[VALUE_W-3:0], 2'b00};
            rem_reg  <= fits ? (rem_shift - trial) : rem_shift;
            root_reg <= {root_reg[RT_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

@@ sv/sss_datapath.sv @@
// ----------------------------------------------------------------------------
// sss_datapath
// Running accumulators, shared divider, mean squaring, variance and root,
// and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sss_datapath #(
    parameter int MAX_SAMPLES = sss_pkg::DEFAULT_MAX_SAMPLES,
    parameter int SAMPLE_BITS = sss_pkg::DEFAULT_SAMPLE_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire sss_pkg::cmd_t                   cmd,
    input  wire logic [sss_pkg::SAMPLE_W-1:0]    sample,
    output sss_pkg::status_t                     status,
    output logic [sss_pkg::OUT_DATA_W-1:0]       out_data,
    output logic                                 out_flag
);

    localparam int SAMPLE_W = sss_pkg::SAMPLE_W;
    localparam int COUNT_W  = sss_pkg::COUNT_W;
    localparam int SUM_W    = sss_pkg::SUM_W;
    localparam int SQSUM_W  = sss_pkg::SQSUM_W;
    localparam int SQUARE_W = sss_pkg::SQUARE_W;
    localparam int VAR_W    = sss_pkg::VAR_W;
    localparam int ROOT_W   = sss_pkg::ROOT_W;
    localparam int PAD_W    = sss_pkg::OUT_DATA_W - sss_pkg::OUT_FIELDS_W;

    logic [SAMPLE_W-1:0] smp;
    logic                room;

    logic [COUNT_W-1:0]  count_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SQSUM_W-1:0]  sqsum_reg;
    logic [SAMPLE_W-1:0] min_reg;
    logic [SAMPLE_W-1:0] max_reg;
    logic                ovf_reg;
    logic [SQUARE_W-1:0] square_reg;
    logic                square_pend_reg;

    logic [SQSUM_W-1:0]  dividend;
    logic [SQSUM_W-1:0]  quotient;
    logic                div_done;
    logic [SAMPLE_W-1:0] mean_reg;
    logic [VAR_W-1:0]    msq_reg;
    logic [VAR_W-1:0]    mean_sq_reg;
    logic [VAR_W-1:0]    var_reg;
    logic [VAR_W-1:0]    var_next;
    logic [ROOT_W-1:0]   root;
    logic                root_done;

    logic [sss_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic                           out_flag_reg;

    assign smp  = SAMPLE_W'(sample[SAMPLE_BITS-1:0]);
    assign room = count_reg < COUNT_W'(MAX_SAMPLES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            sum_reg         <= '0;
            sqsum_reg       <= '0;
            min_reg         <= '1;
            max_reg         <= '0;
            ovf_reg         <= 1'b0;
            square_pend_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            count_reg       <= '0;
            sum_reg         <= '0;
            sqsum_reg       <= '0;
            min_reg         <= '1;
            max_reg         <= '0;
            ovf_reg         <= 1'b0;
            square_pend_reg <= 1'b0;
        end
        else
        begin
            square_pend_reg <= cmd.acc_en && room;
            if (cmd.acc_en)
            begin
                if (room)
                begin
                    count_reg <= count_reg + 1'b1;
                    sum_reg   <= sum_reg + SUM_W'(smp);
                    if (smp < min_reg)
                    begin
                        min_reg <= smp;
                    end
                    if (smp > max_reg)
                    begin
                        max_reg <= smp;
                    end
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            // square lands in the sum in the cycle after its beat
            if (square_pend_reg)
            begin
                sqsum_reg <= sqsum_reg + SQSUM_W'(square_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_en)
        begin
            square_reg <= smp * smp;
        end
    end

    assign dividend = cmd.div_msq ? sqsum_reg : SQSUM_W'(sum_reg);

    sss_divider #(
        .DIVIDEND_W (SQSUM_W),
        .DIVISOR_W  (COUNT_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign var_next = (msq_reg > mean_sq_reg) ? (msq_reg - mean_sq_reg) : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.take_mean)
        begin
            mean_reg <= quotient[SAMPLE_W-1:0];
        end
        if (cmd.take_msq)
        begin
            msq_reg <= quotient[VAR_W-1:0];
        end
        mean_sq_reg <= mean_reg * mean_reg;
        if (cmd.var_load)
        begin
            var_reg <= var_next;
        end
    end

    sss_isqrt #(
        .VALUE_W (VAR_W)
    ) u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.root_start),
        .value (var_reg),
        .done  (root_done),
        .root  (root)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= {{PAD_W{1'b0}}, count_reg, max_reg, min_reg,
                             root, var_reg, mean_reg};
            out_flag_reg <= ovf_reg;
        end
    end

    assign status.div_done  = div_done;
    assign status.root_done = root_done;
    assign out_data         = out_data_reg;
    assign out_flag         = out_flag_reg;

endmodule

`default_nettype wire

@@ sv/sss_controller.sv @@
// ----------------------------------------------------------------------------
// sss_controller
// Sequences accumulation, the two divisions, the variance and the root, and
// owns both stream handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sss_controller (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic             s_tlast,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    input  wire sss_pkg::status_t status,
    output sss_pkg::cmd_t         cmd
);

    sss_pkg::state_t state_reg;
    sss_pkg::state_t state_next;
    logic            m_tvalid_reg;
    logic            out_free;
    logic            accept;

    assign out_free = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && (state_reg == sss_pkg::ST_ACCUM);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sss_pkg::ST_ACCUM:
            begin
                if (accept && s_tlast)
                begin
                    state_next = sss_pkg::ST_MEAN_START;
                end
            end
            sss_pkg::ST_MEAN_START: state_next = sss_pkg::ST_MEAN_WAIT;
            sss_pkg::ST_MEAN_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = sss_pkg::ST_MSQ_START;
                end
            end
            sss_pkg::ST_MSQ_START:  state_next = sss_pkg::ST_MSQ_WAIT;
            sss_pkg::ST_MSQ_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = sss_pkg::ST_VAR;
                end
            end
            sss_pkg::ST_VAR:        state_next = sss_pkg::ST_ROOT_START;
            sss_pkg::ST_ROOT_START: state_next = sss_pkg::ST_ROOT_WAIT;
            sss_pkg::ST_ROOT_WAIT:
            begin
                if (status.root_done)
                begin
                    state_next = sss_pkg::ST_OUTPUT;
                end
            end
            sss_pkg::ST_OUTPUT:
            begin
                if (out_free)
                begin
                    state_next = sss_pkg::ST_ACCUM;
                end
            end
            default:                state_next = sss_pkg::ST_ACCUM;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            sss_pkg::ST_ACCUM:
            begin
                s_tready   = 1'b1;
                cmd.acc_en = s_tvalid;
            end
            sss_pkg::ST_MEAN_START: cmd.div_start = 1'b1;
            sss_pkg::ST_MEAN_WAIT:  cmd.take_mean = status.div_done;
            sss_pkg::ST_MSQ_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_msq   = 1'b1;
            end
            sss_pkg::ST_MSQ_WAIT:   cmd.take_msq   = status.div_done;
            sss_pkg::ST_VAR:        cmd.var_load   = 1'b1;
            sss_pkg::ST_ROOT_START: cmd.root_start = 1'b1;
            sss_pkg::ST_ROOT_WAIT:  cmd.acc_en     = 1'b0;
            sss_pkg::ST_OUTPUT:     cmd.out_load   = out_free;
            default:                cmd            = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sss_pkg::ST_ACCUM;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

@@ sv/sample_set_statistics.sv @@
// ----------------------------------------------------------------------------
// sample_set_statistics
// Running count, mean, variance, deviation, minimum and maximum over sets of
// unsigned samples; one result beat per set.
// ----------------------------------------------------------------------------
//  channel | direction | beat contents
//  s_*     | in        | tdata: sample; tlast: last sample of the set
//  m_*     | out       | tdata: mean, variance, deviation, min, max, count;
//          |           | tuser: overflowed
//
//  samples are taken one per cycle while accumulating
//  after the beat with tlast, intake stops for two 64-step divisions on the
//  shared divider, a 24-step root and the sequencing states
//  the finished result sits in an output register; the next set accumulates
//  while it waits, a second set end waits for it to be taken
//  reset is asynchronous, active low, and clears all accumulators
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sample_set_statistics #(
    parameter int MAX_SAMPLES = sss_pkg::DEFAULT_MAX_SAMPLES,
    parameter int SAMPLE_BITS = sss_pkg::DEFAULT_SAMPLE_BITS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [sss_pkg::IN_DATA_W-1:0]    s_tdata,  // sample
    input  wire logic                             s_tlast,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // mean_value, variance_value, deviation_value, min_value, max_value,
    // sample_count, zero pad
    output logic [sss_pkg::OUT_DATA_W-1:0]        m_tdata,
    output logic                                  m_tuser   // overflowed
);

    sss_pkg::cmd_t    cmd;
    sss_pkg::status_t status;

    sss_controller u_controller (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sss_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sample   (s_tdata[sss_pkg::SAMPLE_W-1:0]),
        .status   (status),
        .out_data (m_tdata),
        .out_flag (m_tuser)
    );

endmodule

`default_nettype wire

@@ sv/sss_checker.sv @@
// ----------------------------------------------------------------------------
// sss_checker
// Port-level checks on the statistics block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sss_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          s_tlast,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [sss_pkg::OUT_DATA_W-1:0] m_tdata
);

    logic [sss_pkg::SAMPLE_W-1:0] mean_f;
    logic [sss_pkg::VAR_W-1:0]    var_f;
    logic [sss_pkg::ROOT_W-1:0]   dev_f;
    logic [sss_pkg::SAMPLE_W-1:0] min_f;
    logic [sss_pkg::SAMPLE_W-1:0] max_f;
    logic [sss_pkg::COUNT_W-1:0]  count_f;
    logic [sss_pkg::VAR_W-1:0]    dev_sq;

    assign mean_f  = m_tdata[23:0];
    assign var_f   = m_tdata[71:24];
    assign dev_f   = m_tdata[95:72];
    assign min_f   = m_tdata[119:96];
    assign max_f   = m_tdata[143:120];
    assign count_f = m_tdata[160:144];
    assign dev_sq  = sss_pkg::VAR_W'(dev_f) * sss_pkg::VAR_W'(dev_f);

    // the set end stops intake while statistics are worked out
    a_stall_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("intake open right after a set end");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped or changed while stalled");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (count_f != '0))
        else $error("result with empty set");

    a_min_mean_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (min_f <= mean_f && mean_f <= max_f))
        else $error("mean outside min and max");

    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (dev_sq <= var_f))
        else $error("deviation squared exceeds variance");

endmodule

bind sample_set_statistics sss_checker u_sss_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sample_set_statistics. Streams sets of samples into
// the block with random gaps, keeps a running model of count, sum, sum of
// squares, minimum and maximum, and compares every result beat against the
// statistics that the model works out at each set end.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int SAMPLE_W   = sss_pkg::SAMPLE_W;
    localparam int COUNT_W    = sss_pkg::COUNT_W;
    localparam int SUM_W      = sss_pkg::SUM_W;
    localparam int SQSUM_W    = sss_pkg::SQSUM_W;
    localparam int VAR_W      = sss_pkg::VAR_W;
    localparam int ROOT_W     = sss_pkg::ROOT_W;
    localparam int IN_DATA_W  = sss_pkg::IN_DATA_W;
    localparam int OUT_DATA_W = sss_pkg::OUT_DATA_W;

    localparam int CAPACITY   = 65536;
    localparam int N_RANDOM   = 700;
    localparam int IDLE_LIMIT = 4000;
    localparam int TAIL_WAIT  = 300;
    localparam int LONG_HOLD  = 600;
    localparam int HOLD_AFTER = 12;
    localparam int MAX_SHOWN  = 10;

    localparam int OFF_VAR = SAMPLE_W;
    localparam int OFF_DEV = OFF_VAR + VAR_W;
    localparam int OFF_LO  = OFF_DEV + ROOT_W;
    localparam int OFF_HI  = OFF_LO + SAMPLE_W;
    localparam int OFF_CNT = OFF_HI + SAMPLE_W;

    localparam bit [SAMPLE_W-1:0] FULL_SCALE = '1;

    typedef struct {
        bit [SAMPLE_W-1:0] value;
        bit                last;
        int unsigned       gap;
        bit                drain;
    } sample_beat_t;

    typedef struct packed {
        bit [SAMPLE_W-1:0] mean;
        bit [VAR_W-1:0]    variance;
        bit [ROOT_W-1:0]   deviation;
        bit [SAMPLE_W-1:0] lo;
        bit [SAMPLE_W-1:0] hi;
        bit [COUNT_W-1:0]  count;
        bit                ovf;
    } set_stats_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // sample
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    // mean, variance, deviation, min, max, count, zero pad
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;   // overflowed

    sample_set_statistics #(
        .MAX_SAMPLES (CAPACITY),
        .SAMPLE_BITS (SAMPLE_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    sample_beat_t sample_q[$];
    set_stats_t   stats_q[$];

    // running set state of the model
    bit [COUNT_W-1:0]  acc_count;
    bit [SUM_W-1:0]    acc_sum;
    bit [SQSUM_W-1:0]  acc_sqsum;
    bit [SAMPLE_W-1:0] acc_lo;
    bit [SAMPLE_W-1:0] acc_hi;
    bit                acc_ovf;

    int unsigned errors;
    int unsigned results_seen;
    int unsigned idle_cycles;
    bit          calm_tx;
    bit          calm_rx;
    bit          in_taken;
    bit          out_taken;
    bit          out_waiting;

    sample_beat_t cur_beat;
    bit           have_beat;
    int unsigned  gap_left;
    int unsigned  rx_wait;
    int unsigned  hold_left;
    bit           hold_done;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void clear_set();
        acc_count = '0;
        acc_sum   = '0;
        acc_sqsum = '0;
        acc_lo    = '1;
        acc_hi    = '0;
        acc_ovf   = 1'b0;
    endfunction

    function automatic bit [ROOT_W-1:0] floor_root(bit [VAR_W-1:0] v);
        bit [ROOT_W-1:0] r;
        bit [VAR_W-1:0]  trial;
        r = '0;
        for (int b = ROOT_W - 1; b >= 0; b--)
        begin
            trial = VAR_W'(r) | (VAR_W'(1) << b);
            if (trial * trial <= v)
                r = trial[ROOT_W-1:0];
        end
        return r;
    endfunction

    // fold one accepted sample into the set; a set end queues its statistics
    function automatic void absorb_sample(bit [SAMPLE_W-1:0] s, bit last);
        set_stats_t st;
        bit [63:0]  mean64;
        bit [63:0]  msq;
        bit [63:0]  m2;
        bit [63:0]  v;
        if (acc_count < CAPACITY)
        begin
            acc_count = acc_count + 1'b1;
            acc_sum   = acc_sum + SUM_W'(s);
            acc_sqsum = acc_sqsum + 64'(s) * 64'(s);
            if (s < acc_lo)
                acc_lo = s;
            if (s > acc_hi)
                acc_hi = s;
        end
        else
            acc_ovf = 1'b1;
        if (last)
        begin
            mean64       = 64'(acc_sum) / 64'(acc_count);
            msq          = acc_sqsum / 64'(acc_count);
            m2           = mean64 * mean64;
            v            = (msq > m2) ? msq - m2 : 64'd0;
            st.mean      = mean64[SAMPLE_W-1:0];
            st.variance  = v[VAR_W-1:0];
            st.deviation = floor_root(v[VAR_W-1:0]);
            st.lo        = acc_lo;
            st.hi        = acc_hi;
            st.count     = acc_count;
            st.ovf       = acc_ovf;
            stats_q.insert(stats_q.size(), st);
            clear_set();
        end
    endfunction

    function automatic void check_result(bit [OUT_DATA_W-1:0] d, bit ovf);
        set_stats_t got;
        set_stats_t want;
        got.mean      = d[0 +: SAMPLE_W];
        got.variance  = d[OFF_VAR +: VAR_W];
        got.deviation = d[OFF_DEV +: ROOT_W];
        got.lo        = d[OFF_LO +: SAMPLE_W];
        got.hi        = d[OFF_HI +: SAMPLE_W];
        got.count     = d[OFF_CNT +: COUNT_W];
        got.ovf       = ovf;
        if (stats_q.size() == 0)
        begin
            errors++;
            if (errors <= MAX_SHOWN)
                $display("unexpected result beat: mean=%0d var=%0d count=%0d",
                         got.mean, got.variance, got.count);
        end
        else
        begin
            want = stats_q.pop_front();
            if (got != want)
            begin
                errors++;
                if (errors <= MAX_SHOWN)
                begin
                    $display("mismatch at result %0d", results_seen);
                    $display("  expected mean=%0d var=%0d dev=%0d min=%0d max=%0d cnt=%0d ovf=%0d",
                             want.mean, want.variance, want.deviation, want.lo, want.hi,
                             want.count, want.ovf);
                    $display("  actual   mean=%0d var=%0d dev=%0d min=%0d max=%0d cnt=%0d ovf=%0d",
                             got.mean, got.variance, got.deviation, got.lo, got.hi,
                             got.count, got.ovf);
                end
            end
        end
    endfunction

    function automatic void push_beat(bit [SAMPLE_W-1:0] value, bit last, int unsigned gap,
                                      bit drain);
        sample_beat_t b;
        b.value = value;
        b.last  = last;
        b.gap   = gap;
        b.drain = drain;
        sample_q.insert(sample_q.size(), b);
    endfunction

    function automatic int unsigned tx_gap();
        return calm_tx ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic bit [SAMPLE_W-1:0] draw_sample(int unsigned mode);
        case (mode)
            0: return SAMPLE_W'($urandom);
            1: return SAMPLE_W'($urandom_range(0, 255));
            2: return FULL_SCALE - SAMPLE_W'($urandom_range(0, 255));
            default:
                case ($urandom_range(0, 2))
                    0: return '0;
                    1: return FULL_SCALE;
                    default: return SAMPLE_W'($urandom);
                endcase
        endcase
    endfunction

    // sampling at the rising edge
    always @(posedge clk)
    begin
        in_taken    <= s_tvalid && s_tready;
        out_taken   <= m_tvalid && m_tready;
        out_waiting <= m_tvalid && !m_tready;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                absorb_sample(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                check_result(m_tdata, m_tuser);
                results_seen++;
            end
        end
    end

    // sample driver
    always @(negedge clk)
    begin : drive_samples
        bit offer;
        offer = s_tvalid && !in_taken;
        if (!offer && rst_n)
        begin
            if (!have_beat && sample_q.size() > 0)
            begin
                cur_beat  = sample_q.pop_front();
                have_beat = 1'b1;
                gap_left  = cur_beat.gap;
            end
            if (have_beat)
            begin
                // hold back until every pending result has come out
                if (cur_beat.drain)
                begin
                    if (stats_q.size() == 0)
                        cur_beat.drain = 1'b0;
                end
                else if (gap_left > 0)
                    gap_left--;
                else
                begin
                    s_tdata   <= cur_beat.value;
                    s_tlast   <= cur_beat.last;
                    offer     = 1'b1;
                    have_beat = 1'b0;
                end
            end
        end
        s_tvalid <= offer;
    end

    // result receiver
    always @(negedge clk)
    begin
        if (out_taken)
        begin
            if ($urandom_range(0, 7) == 0)
                calm_rx = !calm_rx;
            rx_wait = calm_rx ? 0 : $urandom_range(0, 4);
        end
        // one long back-pressure stretch so the block fills and stalls its input
        if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (rx_wait > 0)
        begin
            if (out_waiting)
                rx_wait--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int unsigned n_rand;
        int unsigned n_sets;
        int unsigned len;
        int unsigned mode;
        bit          drain;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        calm_tx  = 1'b0;
        calm_rx  = 1'b0;
        rx_wait  = $urandom_range(0, 4);
        clear_set();

        // single-sample sets at both ends of the range
        push_beat('0, 1'b1, tx_gap(), 1'b0);
        push_beat(FULL_SCALE, 1'b1, tx_gap(), 1'b0);
        // widest spread: zero and full scale
        push_beat('0, 1'b0, tx_gap(), 1'b0);
        push_beat(FULL_SCALE, 1'b1, tx_gap(), 1'b0);
        push_beat(FULL_SCALE, 1'b0, tx_gap(), 1'b0);
        push_beat(FULL_SCALE, 1'b0, tx_gap(), 1'b0);
        push_beat(FULL_SCALE, 1'b1, tx_gap(), 1'b0);
        push_beat(24'hAAAAAA, 1'b0, tx_gap(), 1'b0);
        push_beat(24'h555555, 1'b1, tx_gap(), 1'b0);
        for (int i = 1; i <= 10; i++)
            push_beat(SAMPLE_W'(i), i == 10, tx_gap(), 1'b0);
        push_beat(24'd7, 1'b0, tx_gap(), 1'b0);
        push_beat(24'd7, 1'b0, tx_gap(), 1'b0);
        push_beat(24'd8, 1'b1, tx_gap(), 1'b0);

        n_rand = 0;
        n_sets = 0;
        drain  = 1'b1;
        while (n_rand < N_RANDOM)
        begin
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
            mode = $urandom_range(0, 3);
            if ($urandom_range(0, 5) == 0)
                calm_tx = !calm_tx;
            for (int i = 0; i < len; i++)
                push_beat(draw_sample(mode), i == len - 1, tx_gap(), drain && i == 0);
            n_rand += len;
            n_sets++;
            drain = (n_sets == 25);
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (sample_q.size() != 0 || have_beat || s_tvalid || stats_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        if (errors == 0 && stats_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
sv/sss_pkg.sv
sv/sss_divider.sv
sv/sss_isqrt.sv
sv/sss_datapath.sv
sv/sss_controller.sv
sv/sample_set_statistics.sv
sv/sss_checker.sv
tb/tb_top.sv
